>>> rtl/sf_pkg.sv
// sf_pkg: shared types and constants of the 3x3 sharpen filter
// no dependencies; used by the interfaces and every rtl module but sf_line_store

package sf_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_DATA_W-1:0] DIM_MIN      = 13'd3;
  localparam logic [CFG_DATA_W-1:0] MAX_HEIGHT   = 13'd4096;

  // pixel and coordinate widths
  localparam int CHAN_W  = 8;
  localparam int COORD_W = 12;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

  // four channels, index 3 is alpha, 0 is blue
  typedef logic [3:0][CHAN_W-1:0] argb_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  alpha;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               frame_done;
  } result_t;

endpackage

>>> rtl/sf_if.sv
// sf_if: valid/ready channel interfaces for incoming pixels and results
// depends on sf_pkg for the field widths

interface sf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sf_pkg::CHAN_W-1:0] alpha;
  logic [sf_pkg::CHAN_W-1:0] red;
  logic [sf_pkg::CHAN_W-1:0] green;
  logic [sf_pkg::CHAN_W-1:0] blue;

  modport source (output valid, alpha, red, green, blue, input ready);
  modport sink   (input valid, alpha, red, green, blue, output ready);
endinterface

interface sf_res_if;
  logic                       valid;
  logic                       ready;
  logic [sf_pkg::CHAN_W-1:0]  alpha;
  logic [sf_pkg::CHAN_W-1:0]  red;
  logic [sf_pkg::CHAN_W-1:0]  green;
  logic [sf_pkg::CHAN_W-1:0]  blue;
  logic [sf_pkg::COORD_W-1:0] column;
  logic [sf_pkg::COORD_W-1:0] row;
  logic                       frame_done;

  modport source (output valid, alpha, red, green, blue, column, row, frame_done,
                  input ready);
  modport sink   (input valid, alpha, red, green, blue, column, row, frame_done,
                  output ready);
endinterface

>>> rtl/sf_line_store.sv
// sf_line_store: one row of pixels, one write and one registered read port
// no package dependency

module sf_line_store #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/sf_lane.sv
// sf_lane: sharpen of one color channel, 5*center minus four neighbors, clamped
// depends on sf_pkg for the channel width

module sf_lane (
  input  logic [sf_pkg::CHAN_W-1:0] cen,
  input  logic [sf_pkg::CHAN_W-1:0] left,
  input  logic [sf_pkg::CHAN_W-1:0] right,
  input  logic [sf_pkg::CHAN_W-1:0] up,
  input  logic [sf_pkg::CHAN_W-1:0] down,
  output logic [sf_pkg::CHAN_W-1:0] res
);

  logic [10:0]        gain;
  logic [9:0]         nsum;
  logic signed [11:0] diff;

  // gain of five as shift plus add
  assign gain = {1'b0, cen, 2'b00} + {3'b000, cen};
  assign nsum = {2'b00, left} + {2'b00, right} + {2'b00, up} + {2'b00, down};
  assign diff = $signed({1'b0, gain}) - $signed({2'b00, nsum});

  // clamp to the channel range on both sides
  always_comb begin
    if (diff < 12'sd0) begin
      res = '0;
    end else if (diff > $signed({4'b0000, sf_pkg::CHAN_MAX})) begin
      res = sf_pkg::CHAN_MAX;
    end else begin
      res = diff[7:0];
    end
  end

endmodule

>>> rtl/sf_out_skid.sv
// sf_out_skid: output register plus one skid entry for finished results
// depends on sf_pkg (result_t) and sf_if (sf_res_if)

module sf_out_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sf_pkg::result_t push_data,
  output logic            push_ready,
  sf_res_if.source        out
);

  logic            out_valid_r;
  sf_pkg::result_t out_data_r;
  logic            skid_valid_r;
  sf_pkg::result_t skid_data_r;
  logic            out_free;

  assign out_free   = !out_valid_r || out.ready;
  assign push_ready = !skid_valid_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out.valid      = out_valid_r;
  assign out.alpha      = out_data_r.alpha;
  assign out.red        = out_data_r.red;
  assign out.green      = out_data_r.green;
  assign out.blue       = out_data_r.blue;
  assign out.column     = out_data_r.column;
  assign out.row        = out_data_r.row;
  assign out.frame_done = out_data_r.frame_done;

`ifndef NO_ASSERTIONS
  // the skid entry only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without output beat");

  // nothing is pushed while the skid entry is occupied
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("result pushed into full skid buffer");

  // a stalled skid entry moves to the output as soon as it is taken
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out.ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry did not drain");
`endif

endmodule

>>> rtl/sharpen_filter_3x3_top.sv
// sharpen_filter_3x3_top: streaming 3x3 cross sharpen of ARGB8888 pixels
// channels: in_pix (pixel beats in raster order), out_res (sharpened beats)
// config: cfg_we / cfg_index / cfg_data write image width (0) and height (1)
// every config write restarts the frame at column 0, row 0
// throughput: one pixel per cycle while in_pix.ready is high; the two line
// stores read ahead at the next column; one read and one write per pixel
// the result for the pixel one row and one column back is registered, into
// the output or the skid entry, on the pixel beat that completes its window
// border pixels give no output beat; frame_done marks the last one of a frame
// reset: counters to zero, width 640, height 480, output empty; the line
// stores are not cleared, no unwritten entry reaches a result in a frame
// stall: one skid entry holds a result while out_res is stalled; in_pix.ready
// drops only while that entry is occupied
// depends on sf_pkg, sf_if, sf_line_store, sf_lane, sf_out_skid

module sharpen_filter_3x3_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sf_pix_if.sink                        in_pix,
  sf_res_if.source                      out_res,
  input  logic                          cfg_we,
  input  logic [sf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [sf_pkg::CFG_DATA_W-1:0] width_r;
  logic [sf_pkg::CFG_DATA_W-1:0] height_r;
  logic [WW-1:0]                 w_eff;
  logic [sf_pkg::CFG_DATA_W-1:0] h_eff;

  logic [CW-1:0]              col_r, col_nxt;
  logic [sf_pkg::COORD_W-1:0] row_r, row_nxt;
  logic                       col_last, row_last;
  logic [CW-1:0]              rd_addr;

  logic           accept, push, push_ready, has_result;
  sf_pkg::argb_t  px, up_px, mid_px;
  sf_pkg::argb_t  win_up_r, win_cen_r, win_dn_r, win_left_r;
  sf_pkg::argb_t  lane_res;
  sf_pkg::result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sf_pkg::WIDTH_RESET;
      height_r <= sf_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sf_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        sf_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (width_r < sf_pkg::DIM_MIN) begin
      w_eff = WW'(32'(sf_pkg::DIM_MIN));
    end else begin
      w_eff = WW'(32'(width_r));
    end
    if (height_r > sf_pkg::MAX_HEIGHT) begin
      h_eff = sf_pkg::MAX_HEIGHT;
    end else if (height_r < sf_pkg::DIM_MIN) begin
      h_eff = sf_pkg::DIM_MIN;
    end else begin
      h_eff = height_r;
    end
  end

  assign in_pix.ready = push_ready;
  assign accept       = in_pix.valid && push_ready;
  assign px           = {in_pix.alpha, in_pix.red, in_pix.green, in_pix.blue};

  assign col_last   = 32'(col_r) == 32'(w_eff) - 32'd1;
  assign row_last   = {1'b0, row_r} == h_eff - 13'd1;
  assign has_result = (row_r >= 12'd2) && (32'(col_r) >= 32'd2);
  assign push       = accept && has_result;

  // raster position of the next pixel
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + 12'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores read ahead at the next column
  assign rd_addr = rst_n ? col_nxt : '0;

  sf_line_store #(.DEPTH(MAX_WIDTH), .WIDTH(32)) u_older (
    .clk     (clk),
    .we      (accept),
    .wr_addr (col_r),
    .wr_data (mid_px),
    .rd_addr (rd_addr),
    .rd_data (up_px)
  );

  sf_line_store #(.DEPTH(MAX_WIDTH), .WIDTH(32)) u_newer (
    .clk     (clk),
    .we      (accept),
    .wr_addr (col_r),
    .wr_data (px),
    .rd_addr (rd_addr),
    .rd_data (mid_px)
  );

  // window of the previous two columns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_up_r   <= '0;
      win_cen_r  <= '0;
      win_dn_r   <= '0;
      win_left_r <= '0;
    end else if (accept) begin
      win_left_r <= win_cen_r;
      win_up_r   <= up_px;
      win_cen_r  <= mid_px;
      win_dn_r   <= px;
    end
  end

  // one lane per channel
  for (genvar k = 0; k < 4; k++) begin : g_lane
    sf_lane u_lane (
      .cen   (win_cen_r[k]),
      .left  (win_left_r[k]),
      .right (mid_px[k]),
      .up    (win_up_r[k]),
      .down  (win_dn_r[k]),
      .res   (lane_res[k])
    );
  end

  // merge lanes and position into one result beat
  always_comb begin
    res.alpha      = lane_res[3];
    res.red        = lane_res[2];
    res.green      = lane_res[1];
    res.blue       = lane_res[0];
    res.column     = sf_pkg::COORD_W'(32'(col_r) - 32'd1);
    res.row        = row_r - 12'd1;
    res.frame_done = row_last && col_last;
  end

  sf_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .push_ready (push_ready),
    .out        (out_res)
  );

`ifndef NO_ASSERTIONS
  // raster position stays inside the configured frame
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(w_eff))
    else $error("column counter outside frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < h_eff)
    else $error("row counter outside frame height");

  // frame end wraps the raster position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && col_last && row_last) |=> (col_r == '0 && row_r == '0))
    else $error("raster position did not wrap at frame end");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for sharpen_filter_3x3_top, streams raster frames of
// several sizes and checks every sharpened beat against an in-bench line-store model
// depends on sf_pkg, sf_if and the filter rtl

module tb_top;

  localparam int MAX_W         = 4096;
  localparam int CENTRE_GAIN   = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_MAX    = 10;
  localparam int LIMIT_CYCLES  = 100000;
  localparam int RANDOM_ITEMS  = 300;
  localparam int HOLD_W        = 12;
  localparam int HOLD_H        = 6;
  localparam int SPLIT_H       = 9;
  localparam int SPLIT_ROWS    = 4;

  typedef logic [sf_pkg::CFG_DATA_W-1:0] dim_t;
  typedef enum {SET_BOTH, SET_WIDTH, SET_HEIGHT} cfg_scope_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [sf_pkg::CFG_IDX_W-1:0] cfg_index;
  dim_t                         cfg_data;

  sf_pix_if in_pix ();
  sf_res_if out_res ();

  sharpen_filter_3x3_top #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // model state: two line stores, a two-column window, raster position, frame size
  // window [0..2] holds top/mid/bottom of the previous column, [3..5] the one before
  sf_pkg::argb_t older_line [MAX_W];
  sf_pkg::argb_t newer_line [MAX_W];
  sf_pkg::argb_t window [6];
  int unsigned   col_pos;
  int unsigned   row_pos;
  dim_t          width_reg;
  dim_t          height_reg;

  sf_pkg::result_t sharpened_q [$];
  sf_pkg::argb_t   raster_q [$];
  int unsigned pixels_pushed   = 0;
  int unsigned pixels_accepted = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  logic        pix_taken       = 1'b0;
  logic        hold_request    = 1'b0;
  logic        hold_done       = 1'b0;

  // clock and known input levels from time zero
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = sf_pkg::REG_IMAGE_WIDTH;
    cfg_data      = '0;
    in_pix.valid  = 1'b0;
    in_pix.alpha  = '0;
    in_pix.red    = '0;
    in_pix.green  = '0;
    in_pix.blue   = '0;
    out_res.ready = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input dim_t d, input int unsigned hi);
    if (d < sf_pkg::DIM_MIN) return 32'(sf_pkg::DIM_MIN);
    if (32'(d) > hi) return hi;
    return 32'(d);
  endfunction

  function automatic logic [sf_pkg::CHAN_W-1:0] sharpen_channel(
    input logic [sf_pkg::CHAN_W-1:0] centre, left, right, up, down
  );
    int acc;
    acc = CENTRE_GAIN * int'(centre) - int'(left) - int'(right) - int'(up) - int'(down);
    if (acc < 0) acc = 0;
    else if (acc > int'(sf_pkg::CHAN_MAX)) acc = int'(sf_pkg::CHAN_MAX);
    return acc[sf_pkg::CHAN_W-1:0];
  endfunction

  // advance the model by one pixel, queue the sharpened pixel it completes
  function automatic void predict_sharpen(input sf_pkg::argb_t px);
    int unsigned               w, h, c, r, k;
    sf_pkg::argb_t             above_px, middle_px;
    logic [sf_pkg::CHAN_W-1:0] lane [4];
    sf_pkg::result_t           res;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, 32'(sf_pkg::MAX_HEIGHT));
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    above_px  = older_line[c];
    middle_px = newer_line[c];
    if (r >= 2 && c >= 2) begin
      for (k = 0; k < 4; k++) begin
        lane[k] = sharpen_channel(window[1][k], window[4][k], middle_px[k],
                                  window[0][k], window[2][k]);
      end
      res.alpha      = lane[3];
      res.red        = lane[2];
      res.green      = lane[1];
      res.blue       = lane[0];
      res.column     = sf_pkg::COORD_W'(c - 1);
      res.row        = sf_pkg::COORD_W'(r - 1);
      res.frame_done = (r == h - 1) && (c == w - 1);
      sharpened_q.push_back(res);
    end
    window[3] = window[0];
    window[4] = window[1];
    window[5] = window[2];
    window[0] = above_px;
    window[1] = middle_px;
    window[2] = px;
    older_line[c] = middle_px;
    newer_line[c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // monitor: check result beats, then feed accepted pixel beats to the model
  always @(posedge clk) begin
    sf_pkg::result_t seen, want;
    if (rst_n && out_res.valid && out_res.ready) begin
      seen = {out_res.alpha, out_res.red, out_res.green, out_res.blue,
              out_res.column, out_res.row, out_res.frame_done};
      if (sharpened_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected beat: argb %h %h %h %h col %0d row %0d done %b",
                   seen.alpha, seen.red, seen.green, seen.blue,
                   seen.column, seen.row, seen.frame_done);
      end else begin
        want = sharpened_q.pop_front();
        if (seen.alpha !== want.alpha || seen.red !== want.red ||
            seen.green !== want.green || seen.blue !== want.blue ||
            seen.column !== want.column || seen.row !== want.row ||
            seen.frame_done !== want.frame_done) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("beat mismatch: expected argb %h %h %h %h col %0d row %0d done %b",
                     want.alpha, want.red, want.green, want.blue,
                     want.column, want.row, want.frame_done);
            $display("               actual   argb %h %h %h %h col %0d row %0d done %b",
                     seen.alpha, seen.red, seen.green, seen.blue,
                     seen.column, seen.row, seen.frame_done);
          end
        end
      end
    end
    pix_taken <= rst_n && in_pix.valid && in_pix.ready;
    if (rst_n && in_pix.valid && in_pix.ready) begin
      predict_sharpen({in_pix.alpha, in_pix.red, in_pix.green, in_pix.blue});
      pixels_accepted++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // driver: pixel beats in bursts with random gaps
  always @(negedge clk) begin
    sf_pkg::argb_t beat;
    int unsigned   burst_left;
    int unsigned   gap_left;
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_pix.valid || pix_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_pix.valid <= 1'b0;
      end else if (raster_q.size() > 0) begin
        beat = raster_q.pop_front();
        {in_pix.alpha, in_pix.red, in_pix.green, in_pix.blue} <= beat;
        in_pix.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 64);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_pix.valid <= 1'b0;
      end
    end
  end

  // receiver: stall patterns of random length, plus one long hold-off on request
  always @(negedge clk) begin
    rx_mode_t    rx_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned rx_tick;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      rx_tick   = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_res.ready <= 1'b0;
    end else if (hold_request && !hold_done && out_res.valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_res.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_res.ready <= 1'b1;
        RX_COIN:   out_res.ready <= $urandom_range(0, 1);
        RX_SPARSE: out_res.ready <= ($urandom_range(0, 3) == 0);
        default:   out_res.ready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_accepted != pixels_pushed || sharpened_q.size() != 0);
  endtask

  // border pixels give no beat, so let the pipe run empty before touching registers
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write enable stays high for back-to-back writes, the caller lowers it
  task automatic write_reg(input logic [sf_pkg::CFG_IDX_W-1:0] idx, input dim_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    if (idx == sf_pkg::REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic program_frame(input dim_t w, input dim_t h, input cfg_scope_t scope);
    settle();
    if (scope != SET_HEIGHT) write_reg(sf_pkg::REG_IMAGE_WIDTH, w);
    if (scope != SET_WIDTH) write_reg(sf_pkg::REG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic push_one(input sf_pkg::argb_t px);
    raster_q.push_back(px);
    pixels_pushed++;
  endtask

  // one 3x3 frame in raster order around a single interior pixel
  task automatic push_cross(input sf_pkg::argb_t centre, up, left, right, down, corner);
    push_one(corner); push_one(up);     push_one(corner);
    push_one(left);   push_one(centre); push_one(right);
    push_one(corner); push_one(down);   push_one(corner);
  endtask

  // smooth content keeps neighbors close so results land mid-range
  task automatic push_pixels(input int unsigned n, input bit smooth);
    sf_pkg::argb_t             px;
    logic [sf_pkg::CHAN_W-1:0] base;
    int unsigned               i, k;
    base = sf_pkg::CHAN_W'($urandom_range(0, 240));
    for (i = 0; i < n; i++) begin
      if (smooth) begin
        for (k = 0; k < 4; k++) px[k] = sf_pkg::CHAN_W'(32'(base) + $urandom_range(0, 15));
      end else begin
        px = $urandom();
      end
      push_one(px);
    end
  endtask

  function automatic dim_t pick_dim();
    case ($urandom_range(0, 9))
      0:       return dim_t'($urandom_range(0, 2));
      1:       return dim_t'($urandom_range(MAX_W, 8191));
      default: return dim_t'($urandom_range(3, 9));
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned random_items, ew, eh, span, n;
    dim_t        w_pick, h_pick;
    cfg_scope_t  scope;
    width_reg  = sf_pkg::WIDTH_RESET;
    height_reg = sf_pkg::HEIGHT_RESET;
    col_pos    = 0;
    row_pos    = 0;
    foreach (window[i]) window[i] = '0;
    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: smallest frame, overflow far past 255, underflow, per-channel edges
    program_frame(13'd3, 13'd3, SET_BOTH);
    push_cross(32'hffffffff, '0, '0, '0, '0, 32'hffffffff);
    push_cross('0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, '0);
    push_cross({8'd64, 8'd51, 8'd60, 8'd100}, {8'd16, 8'd0, 8'd10, 8'd0},
               {8'd16, 8'd0, 8'd30, 8'd0}, {8'd16, 8'd0, 8'd40, 8'd255},
               {8'd16, 8'd0, 8'd20, 8'd255}, 32'hffffffff);

    // width below the minimum and height past the maximum, a few rows only
    program_frame(13'd0, 13'h1fff, SET_BOTH);
    push_pixels(12, 1'b1);

    // random: small frames, up to three per setting, some cut short by the next write
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      w_pick = pick_dim();
      h_pick = pick_dim();
      scope  = ($urandom_range(0, 3) != 0) ? SET_BOTH : cfg_scope_t'($urandom_range(1, 2));
      program_frame(w_pick, h_pick, scope);
      ew   = clamp_dim(width_reg, MAX_W);
      eh   = clamp_dim(height_reg, 32'(sf_pkg::MAX_HEIGHT));
      span = ew * eh;
      if (span <= 100) begin
        n = span * $urandom_range(1, 3);
        if ($urandom_range(0, 1)) n += $urandom_range(1, span - 1);
      end else begin
        n = $urandom_range(20, 60);
      end
      push_pixels(n, $urandom_range(0, 3) == 0);
      random_items += n;
    end

    // one full frame; the receiver holds off once results flow
    program_frame(dim_t'(HOLD_W), dim_t'(HOLD_H), SET_BOTH);
    hold_request = 1'b1;
    push_pixels(HOLD_W * HOLD_H, 1'b0);

    // narrowest width, sender pauses mid-frame until drained
    program_frame(13'd2, dim_t'(SPLIT_H), SET_BOTH);
    push_pixels(3 * SPLIT_ROWS, 1'b1);
    wait_drained();
    push_pixels(3 * (SPLIT_H - SPLIT_ROWS), 1'b0);

    settle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
